[rtl/core/dmo_pkg.sv]
// ----------------------------------------------------------------------------
// dmo_pkg
// Shared constants, types and the arctangent table of the dual-mouse odometry.
// ----------------------------------------------------------------------------
package dmo_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int ATAN_IDX_W   = 5;

	localparam int IN_W   = 16;
	localparam int PROD_W = 2 * IN_W;
	localparam int ROT_W  = PROD_W + 1;
	localparam int DIFF_W = ROT_W + 1;
	localparam int CORD_W = DIFF_W + 2;
	localparam int ANG_W  = 17;
	localparam int ACC_W  = 48;
	localparam int HEAD_W = 16;
	localparam int FRAC_W = 14;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_COS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIN = 1'd1;

	localparam logic signed [ANG_W-1:0] HALF_PI = 17'sd25736;

	typedef struct packed {
		logic signed [ROT_W-1:0] x;
		logic signed [ROT_W-1:0] y;
	} rot_res_t;

	// atan(2^-i) in Q2.14, rounded to nearest
	function automatic logic signed [ANG_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			5'd0:    v = 17'sd12868;
			5'd1:    v = 17'sd7596;
			5'd2:    v = 17'sd4014;
			5'd3:    v = 17'sd2037;
			5'd4:    v = 17'sd1023;
			5'd5:    v = 17'sd512;
			5'd6:    v = 17'sd256;
			5'd7:    v = 17'sd128;
			5'd8:    v = 17'sd64;
			5'd9:    v = 17'sd32;
			5'd10:   v = 17'sd16;
			5'd11:   v = 17'sd8;
			5'd12:   v = 17'sd4;
			5'd13:   v = 17'sd2;
			5'd14:   v = 17'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[rtl/core/dmo_rotate.sv]
// ----------------------------------------------------------------------------
// dmo_rotate
// Rotates the second reading by the mount angle with one shared multiplier
// and an accumulator for each of x (subtract) and y (add), one product per cycle.
// ----------------------------------------------------------------------------
module dmo_rotate import dmo_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [IN_W-1:0] rx,
	input  logic signed [IN_W-1:0] ry,
	input  logic signed [IN_W-1:0] cos_val,
	input  logic signed [IN_W-1:0] sin_val,
	output logic                   done,
	output rot_res_t               res
);

	localparam logic [2:0] PH_XC = 3'd0;
	localparam logic [2:0] PH_YS = 3'd1;
	localparam logic [2:0] PH_XS = 3'd2;
	localparam logic [2:0] PH_YC = 3'd3;
	localparam logic [2:0] PH_FIN = 3'd4;

	logic [2:0]               phase_q;
	logic                     busy_q;
	logic                     done_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ROT_W-1:0]  x_q;
	logic signed [ROT_W-1:0]  y_q;
	logic signed [IN_W-1:0]   op_a;
	logic signed [IN_W-1:0]   op_b;
	logic signed [ROT_W-1:0]  prod_ext;

	assign op_a     = (phase_q == PH_XC || phase_q == PH_XS) ? rx : ry;
	assign op_b     = (phase_q == PH_XC || phase_q == PH_YC) ? cos_val : sin_val;
	assign prod_ext = ROT_W'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_XC;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= PH_XC;
			end else if (busy_q) begin
				if (phase_q == PH_FIN) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					phase_q <= phase_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			prod_q <= op_a * op_b;
			unique case (phase_q)
				PH_YS:   x_q <= prod_ext;
				PH_XS:   x_q <= x_q - prod_ext;
				PH_YC:   y_q <= prod_ext;
				PH_FIN:  y_q <= y_q + prod_ext;
				default: ;
			endcase
		end
	end

	assign done  = done_q;
	assign res.x = x_q;
	assign res.y = y_q;

endmodule

[rtl/core/dmo_cordic.sv]
// ----------------------------------------------------------------------------
// dmo_cordic
// Vectoring CORDIC: one shift/add/sub unit iterated CORDIC_STEPS times,
// with the half-plane fold and the zero-dx case.
// ----------------------------------------------------------------------------
module dmo_cordic import dmo_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIFF_W-1:0] dx,
	input  logic signed [DIFF_W-1:0] dy,
	output logic                     done,
	output logic signed [HEAD_W-1:0] heading
);

	logic                     busy_q;
	logic                     done_q;
	logic [STEP_W-1:0]        cnt_q;
	logic signed [CORD_W-1:0] x_q;
	logic signed [CORD_W-1:0] y_q;
	logic signed [ANG_W-1:0]  z_q;
	logic signed [CORD_W-1:0] dx_ext;
	logic signed [CORD_W-1:0] dy_ext;
	logic signed [CORD_W-1:0] sx;
	logic signed [CORD_W-1:0] sy;
	logic signed [ANG_W-1:0]  ang;

	assign dx_ext = CORD_W'(dx);
	assign dy_ext = CORD_W'(dy);
	assign sx     = x_q >>> cnt_q;
	assign sy     = y_q >>> cnt_q;
	assign ang    = atan_lut(ATAN_IDX_W'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (dx == '0)
					done_q <= 1'b1;
				else
					busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (dx == '0) begin
				z_q <= (dy > 0) ? HALF_PI : -HALF_PI;
			end else begin
				z_q <= '0;
				x_q <= (dx < 0) ? -dx_ext : dx_ext;
				y_q <= (dx < 0) ? -dy_ext : dy_ext;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - ang;
			end
		end
	end

	always_comb begin
		if (z_q > HALF_PI)
			heading = HEAD_W'(HALF_PI);
		else if (z_q < -HALF_PI)
			heading = HEAD_W'(-HALF_PI);
		else
			heading = HEAD_W'(z_q);
	end

	assign done = done_q;

endmodule

[rtl/core/dual_mouse_odometry.sv]
// ----------------------------------------------------------------------------
// dual_mouse_odometry
// Two-mouse odometry: rotated mean step into a saturating centre position,
// and heading of the difference vector by CORDIC.
// ----------------------------------------------------------------------------
// Input stream s_axis: one transfer carries both mouse readings. Output
// stream m_axis: one transfer per input with centre x/y (Q34.14) and
// heading (Q2.14). The config port writes the mount cosine (index 0) and
// sine (index 1), one per write; write only while the block is idle.
// An item passes from the input transfer to output valid through these steps:
// the rotation, which runs the 4 products through one 16x16 multiplier (start,
// four products, final sum) and sets the difference and the accumulated
// position as it finishes; the start and load of the CORDIC; CORDIC_STEPS (16)
// iterations of one shift/add unit; and the hand-off of the heading to the
// output register. When dx is zero the iterations are skipped. The input is not
// ready during that work; it is ready again the cycle after the result is
// loaded, so a new item is not taken before the last one is in the output
// register. The result sits in that register, so a new item is taken while it
// waits; a stalled receiver holds the block at the end of the next item until
// the register frees.
// Reset clears the position to zero, sets cos=1.0 and sin=0, and drops
// all valid flags.
// ----------------------------------------------------------------------------
module dual_mouse_odometry import dmo_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// first_x, first_y, second_x, second_y
	input  logic [63:0]          s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// centre_x, centre_y, heading
	output logic [111:0]         m_axis_tdata
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROT  = 3'd1;
	localparam logic [2:0] ST_DIFF = 3'd2;
	localparam logic [2:0] ST_COR  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]               state_q;
	logic                     rot_start_q;
	logic                     cor_start_q;
	logic signed [IN_W-1:0]   cos_q;
	logic signed [IN_W-1:0]   sin_q;
	logic signed [IN_W-1:0]   fx_q;
	logic signed [IN_W-1:0]   fy_q;
	logic signed [IN_W-1:0]   sx_q;
	logic signed [IN_W-1:0]   sy_q;
	logic signed [ACC_W-1:0]  pos_x_q;
	logic signed [ACC_W-1:0]  pos_y_q;
	logic signed [DIFF_W-1:0] dx_q;
	logic signed [DIFF_W-1:0] dy_q;
	logic                     m_valid_q;
	logic [111:0]             m_data_q;

	logic                     accept;
	logic                     rot_done;
	rot_res_t                 rot_res;
	logic                     cor_done;
	logic signed [HEAD_W-1:0] cor_heading;
	logic                     out_load;
	logic signed [DIFF_W-1:0] x1;
	logic signed [DIFF_W-1:0] y1;
	logic signed [DIFF_W-1:0] sum_x;
	logic signed [DIFF_W-1:0] sum_y;
	logic signed [ACC_W:0]    nx;
	logic signed [ACC_W:0]    ny;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

	dmo_rotate u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rot_start_q),
		.rx      (sx_q),
		.ry      (sy_q),
		.cos_val (cos_q),
		.sin_val (sin_q),
		.done    (rot_done),
		.res     (rot_res)
	);

	dmo_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start_q),
		.dx      (dx_q),
		.dy      (dy_q),
		.done    (cor_done),
		.heading (cor_heading)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= 16'sd16384;
			sin_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COS: cos_q <= cfg_data;
				REG_SIN: sin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rot_start_q <= 1'b0;
			cor_start_q <= 1'b0;
		end else begin
			rot_start_q <= 1'b0;
			cor_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					state_q     <= ST_ROT;
					rot_start_q <= 1'b1;
				end
				ST_ROT: if (rot_done) begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					state_q     <= ST_COR;
					cor_start_q <= 1'b1;
				end
				ST_COR: if (cor_done) begin
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_load) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fx_q <= s_axis_tdata[15:0];
			fy_q <= s_axis_tdata[31:16];
			sx_q <= s_axis_tdata[47:32];
			sy_q <= s_axis_tdata[63:48];
		end
	end

	// first reading scaled to Q.14
	assign x1    = DIFF_W'(fx_q) <<< FRAC_W;
	assign y1    = DIFF_W'(fy_q) <<< FRAC_W;
	assign sum_x = x1 + DIFF_W'(rot_res.x);
	assign sum_y = y1 + DIFF_W'(rot_res.y);
	// floor of half the sum, added with one guard bit
	assign nx    = (ACC_W + 1)'(pos_x_q) + (ACC_W + 1)'(sum_x >>> 1);
	assign ny    = (ACC_W + 1)'(pos_y_q) + (ACC_W + 1)'(sum_y >>> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
		end else if (state_q == ST_ROT && rot_done) begin
			if (nx[ACC_W] != nx[ACC_W-1])
				pos_x_q <= nx[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
			else
				pos_x_q <= nx[ACC_W-1:0];
			if (ny[ACC_W] != ny[ACC_W-1])
				pos_y_q <= ny[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
			else
				pos_y_q <= ny[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ROT && rot_done) begin
			dx_q <= DIFF_W'(rot_res.x) - x1;
			dy_q <= DIFF_W'(rot_res.y) - y1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_load)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_data_q <= {cor_heading, pos_y_q, pos_x_q};
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("input ready right after a transfer");

	a_rot_cor_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(rot_done && cor_done))
		else $error("rotation and cordic finished together");

	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("output valid raised outside result state");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[111:96]) <= 16'sd25736 &&
			$signed(m_axis_tdata[111:96]) >= -16'sd25736))
		else $error("heading outside half-pi range");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: dual_mouse_odometry testbench
// Drives mouse reading pairs over the input stream and mount angles over the
// config port. Every transfer goes into a pose tracker that keeps its own
// saturating centre position and its own CORDIC heading. Each output transfer
// is compared field by field with the oldest pending pose. The stimulus has a
// directed part under several mount angles, a back-to-back pass of the largest
// positive x step, and random phases with random gaps on both sides but the last.
// ----------------------------------------------------------------------------
import dmo_pkg::*;

localparam longint ACC_TOP     = 64'sh0000_7FFF_FFFF_FFFF;
localparam longint ACC_BOT     = -ACC_TOP - 1;
localparam int     HALF_PI_Q14 = 25736;

typedef struct packed {
	logic signed [47:0] cx;
	logic signed [47:0] cy;
	logic signed [15:0] hd;
} pose_t;

// atan(2^-i), Q2.14
function automatic int atan_q14(input int i);
	case (i)
		0:       return 12868;
		1:       return 7596;
		2:       return 4014;
		3:       return 2037;
		4:       return 1023;
		5:       return 512;
		6:       return 256;
		7:       return 128;
		8:       return 64;
		9:       return 32;
		10:      return 16;
		11:      return 8;
		12:      return 4;
		13:      return 2;
		14:      return 1;
		default: return 0;
	endcase
endfunction

class pose_tracker;
	logic signed [15:0] mount_cos;
	logic signed [15:0] mount_sin;
	longint             acc_x;
	longint             acc_y;
	pose_t              pose_due[$];
	int                 errors;

	function new();
		mount_cos = 16'sd16384;
		mount_sin = 16'sd0;
		acc_x     = 0;
		acc_y     = 0;
		errors    = 0;
	endfunction

	function longint clamp48(input longint v);
		if (v > ACC_TOP)
			return ACC_TOP;
		if (v < ACC_BOT)
			return ACC_BOT;
		return v;
	endfunction

	// vectoring CORDIC, folded to the right half plane
	function int cordic_heading(input longint dx, input longint dy);
		longint x, y, nx, ny;
		int     z;
		if (dx == 0)
			return (dy > 0) ? HALF_PI_Q14 : -HALF_PI_Q14;
		if (dx < 0) begin
			dx = -dx;
			dy = -dy;
		end
		x = dx;
		y = dy;
		z = 0;
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z  = z + atan_q14(i);
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z  = z - atan_q14(i);
			end
			x = nx;
			y = ny;
		end
		if (z > HALF_PI_Q14)
			z = HALF_PI_Q14;
		if (z < -HALF_PI_Q14)
			z = -HALF_PI_Q14;
		return z;
	endfunction

	function void note_reading(input logic [63:0] d);
		longint fx, fy, sx, sy, c, s, x1, y1, x2, y2;
		pose_t  p;
		fx = $signed(d[15:0]);
		fy = $signed(d[31:16]);
		sx = $signed(d[47:32]);
		sy = $signed(d[63:48]);
		c  = mount_cos;
		s  = mount_sin;
		x1 = fx * 16384;
		y1 = fy * 16384;
		x2 = sx * c - sy * s;
		y2 = sx * s + sy * c;
		acc_x = clamp48(acc_x + ((x1 + x2) >>> 1));
		acc_y = clamp48(acc_y + ((y1 + y2) >>> 1));
		p.cx = acc_x[47:0];
		p.cy = acc_y[47:0];
		p.hd = 16'(cordic_heading(x2 - x1, y2 - y1));
		pose_due.push_back(p);
	endfunction

	task report(input string what, input longint got_v, input longint ref_v);
		$display("mismatch %s: got %0d, predicted %0d", what, got_v, ref_v);
		errors++;
	endtask

	task check_pose(input logic [111:0] d);
		pose_t  p;
		longint gx, gy, gh;
		gx = $signed(d[47:0]);
		gy = $signed(d[95:48]);
		gh = $signed(d[111:96]);
		if (pose_due.size() == 0) begin
			report("transfer with nothing pending", gx, 0);
			return;
		end
		p = pose_due.pop_front();
		if (gx != longint'(p.cx))
			report("centre_x", gx, p.cx);
		if (gy != longint'(p.cy))
			report("centre_y", gy, p.cy);
		if (gh != longint'(p.hd))
			report("heading", gh, p.hd);
	endtask
endclass

module tb;

	localparam int LONG_HOLD_CYC  = 300;
	localparam int SETTLE_CYC     = 40;
	localparam int PHASE_ITEMS    = 125;
	localparam int MAX_STEP_ITEMS = 40;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	// first_x, first_y, second_x, second_y
	logic [63:0]          s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// centre_x, centre_y, heading
	logic [111:0]         m_axis_tdata;

	pose_tracker trk = new();
	bit          tx_idle;
	bit          rx_idle;
	bit          rx_long_hold;

	dual_mouse_odometry u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#180_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			trk.check_pose(m_axis_tdata);
	end

	// receiver: random stalls, plus one long hold on request
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD_CYC) @(posedge clk);
				rx_long_hold = 1'b0;
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic logic [63:0] pack_reading(input logic [15:0] fx, input logic [15:0] fy,
			input logic [15:0] sx, input logic [15:0] sy);
		return {sy, sx, fy, fx};
	endfunction

	function automatic logic [15:0] rand_count();
		case ($urandom_range(0, 9))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'($urandom_range(0, 16) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] rand_reading();
		logic [15:0] fx, fy, sx, sy;
		fx = rand_count();
		fy = rand_count();
		sx = rand_count();
		sy = rand_count();
		// same x on both mice: zero dx under an unrotated mount
		if ($urandom_range(0, 7) == 0)
			sx = fx;
		return pack_reading(fx, fy, sx, sy);
	endfunction

	task automatic send_reading(input logic [63:0] word);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		trk.note_reading(word);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (trk.pose_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_mount(input logic [15:0] c, input logic [15:0] s);
		cfg_we    <= 1'b1;
		cfg_index <= REG_COS;
		cfg_data  <= c;
		@(posedge clk);
		cfg_index <= REG_SIN;
		cfg_data  <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
		trk.mount_cos = c;
		trk.mount_sin = s;
	endtask

	initial begin
		int          n;
		int          ph;
		logic [15:0] c;
		logic [15:0] s;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_COS;
		cfg_data      = 16'h0000;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 64'h0;
		tx_idle       = 1'b1;
		rx_idle       = 1'b1;
		rx_long_hold  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unrotated mount: zero dx with dy positive, zero and negative, then nonzero dx and extremes
		set_mount(16'sd16384, 16'sd0);
		send_reading(pack_reading(16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_reading(pack_reading(16'h0000, 16'h0000, 16'h0000, 16'h0005));
		send_reading(pack_reading(16'h0000, 16'h0000, 16'h0000, 16'hfffb));
		send_reading(pack_reading(16'h0000, 16'h0000, 16'hfffd, 16'h0004));
		send_reading(pack_reading(16'h0000, 16'h0000, 16'h0003, 16'hfffc));
		send_reading(pack_reading(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
		send_reading(pack_reading(16'h8000, 16'h8000, 16'h8000, 16'h8000));
		send_reading(pack_reading(16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
		send_reading(pack_reading(16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
		send_reading(pack_reading(16'h0000, 16'h8000, 16'h0001, 16'h7fff));
		send_reading(pack_reading(16'h0000, 16'h7fff, 16'hffff, 16'h8000));
		send_reading(pack_reading(16'h0001, 16'h0000, 16'h0000, 16'h0000));
		send_reading(pack_reading(16'hffff, 16'hffff, 16'h0000, 16'h0000));

		// 45 degree mount
		drain();
		set_mount(16'sd11585, 16'sd11585);
		send_reading(pack_reading(16'h0000, 16'h0000, 16'h0001, 16'h0000));
		send_reading(pack_reading(16'h0000, 16'h0000, 16'h0001, 16'hffff));
		send_reading(pack_reading(16'h0005, 16'h0007, 16'hfff7, 16'h0003));
		send_reading(pack_reading(16'h7fff, 16'h8000, 16'h8000, 16'h8000));

		// mount values beyond unit magnitude
		drain();
		set_mount(16'h8000, 16'h7fff);
		send_reading(pack_reading(16'h7fff, 16'h7fff, 16'h8000, 16'h8000));
		send_reading(pack_reading(16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
		send_reading(pack_reading(16'h0003, 16'hfffe, 16'h0001, 16'h0001));

		// largest positive x step, back to back
		drain();
		set_mount(16'h8000, 16'h8000);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		for (n = 0; n < MAX_STEP_ITEMS; n++)
			send_reading(pack_reading(16'h7fff, 16'h8000, 16'h8000, 16'h7fff));

		for (ph = 0; ph < 10; ph++) begin
			drain();
			case (ph)
				0: begin c = 16'sd16384;  s = 16'sd0;      end
				1: begin c = 16'sd0;      s = 16'sd16384;  end
				2: begin c = -16'sd16384; s = 16'sd0;      end
				3: begin c = 16'sd0;      s = -16'sd16384; end
				4: begin c = -16'sd11585; s = 16'sd11585;  end
				5, 7: begin
					c = 16'($urandom_range(0, 32768) - 16384);
					s = 16'($urandom_range(0, 32768) - 16384);
				end
				6, 8: begin
					c = 16'($urandom);
					s = 16'($urandom);
				end
				default: begin c = 16'h7fff; s = 16'h8000; end
			endcase
			set_mount(c, s);
			tx_idle = (ph != 9);
			rx_idle = (ph != 9);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 2 && n == 30)
					rx_long_hold = 1'b1;
				send_reading(rand_reading());
			end
		end
		drain();

		if (trk.errors == 0 && trk.pose_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
rtl/core/dmo_pkg.sv
rtl/core/dmo_rotate.sv
rtl/core/dmo_cordic.sv
rtl/core/dual_mouse_odometry.sv
tb/tb.sv
